// File: rtl/core/semaphore_fifo_wait_unit_top_assert.svh
// assertion macros for the semaphore fifo wait unit checks
// no dependencies; included by the checker file
`ifndef SEMAPHORE_FIFO_WAIT_UNIT_TOP_ASSERT_SVH
`define SEMAPHORE_FIFO_WAIT_UNIT_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define SFWU_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sfwu same-cycle check failed");

// next-cycle implication, off during reset
`define SFWU_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sfwu next-cycle check failed");

// next-cycle implication, also checked through reset
`define SFWU_ASSERT_NEXT_ALWAYS(name, ante, cons) \
    name: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("sfwu reset check failed");

`endif

// File: rtl/core/sfwu_pkg.sv
// shared types, codes and field widths of the semaphore fifo wait unit
// no dependencies
package sfwu_pkg;

    localparam int DEF_NUM_SEMS    = 16;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int SEM_ID_W  = 4;
    localparam int PROC_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 16;  // sem_id + proc_id, padded to bytes
    localparam int M_TUSER_W = 4;   // status + woken_valid

    typedef enum logic {
        OP_WAIT   = 1'b0,
        OP_SIGNAL = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 3'd0,
        ST_BLOCKED = 3'd1,
        ST_FREED   = 3'd2,
        ST_HANDED  = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

endpackage

// File: rtl/core/sfwu_state_ram.sv
// per-semaphore state memory: {locked, head, count}, registered read
// entries never written read as zero through per-entry valid bits; uses sfwu_pkg
module sfwu_state_ram
    import sfwu_pkg::*;
#(
    parameter int NUM_SEMS = DEF_NUM_SEMS,
    parameter int WIDTH    = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [$clog2(NUM_SEMS)-1:0] rd_addr,
    output logic [WIDTH-1:0]            rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(NUM_SEMS)-1:0] wr_addr,
    input  logic [WIDTH-1:0]            wr_data
);

    logic [WIDTH-1:0]    mem [NUM_SEMS];
    logic [NUM_SEMS-1:0] valid_reg;
    logic [WIDTH-1:0]    rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // old data on a same-edge collision; the caller forwards
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/sfwu_waiter_ram.sv
// waiter id store, one row of slots per semaphore, registered read
// uses sfwu_pkg for the process id width
module sfwu_waiter_ram
    import sfwu_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PROC_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PROC_W-1:0] wr_data
);

    logic [PROC_W-1:0] mem [DEPTH];
    logic [PROC_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/semaphore_fifo_wait_unit_top.sv
// top level of the semaphore fifo wait unit: request pipeline, state and waiter memories
// depends on sfwu_pkg, sfwu_state_ram and sfwu_waiter_ram
// a request accepted is held in stage 1 for its state read, then registered in the output stage
// throughput: one request per cycle while m_tready holds; a stalled result stalls intake
// the state memory read-modify-write loop sets the rate, with forwarding
// reset: synchronous active-low aresetn clears pipeline valids and all semaphore valid bits,
// so every semaphore reads unlocked with an empty queue; no clearing pass is needed
module semaphore_fifo_wait_unit_top
    import sfwu_pkg::*;
#(
    parameter int NUM_SEMS    = DEF_NUM_SEMS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [3:0] sem_id, [11:4] proc_id, [15:12] zero
    input  logic                 s_tuser,   // [0] op
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PROC_W-1:0]    m_tdata,   // [7:0] woken_proc
    output logic [M_TUSER_W-1:0] m_tuser    // [2:0] status, [3] woken_valid
);

    localparam int SEM_W  = $clog2(NUM_SEMS);
    localparam int QW     = $clog2(QUEUE_DEPTH);       // queue slot position
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);   // waiter count, 0..depth
    localparam int SUMW   = CW + 1;                    // head + count before wrap
    localparam int SW     = 1 + QW + CW;               // state word {locked, head, count}
    localparam int WT_AW  = SEM_W + QW;
    localparam int WT_DEP = NUM_SEMS * (2 ** QW);
    localparam int N_IDS  = 2 ** SEM_ID_W;

    // sem_id folded into range, as a constant lookup
    logic [SEM_W-1:0] sem_map [N_IDS];
    for (genvar i = 0; i < N_IDS; i++) begin : g_sem_map
        assign sem_map[i] = SEM_W'(i % NUM_SEMS);
    end

    // handshake and pipeline advance: everything moves together
    logic advance;
    logic accept;

    // stage 1: request waiting on its state read
    logic              s1_valid_reg, s1_valid_next;
    op_t               s1_op_reg;
    logic [SEM_W-1:0]  s1_sem_reg;
    logic [PROC_W-1:0] s1_proc_reg;

    // forwarding of the state write that lands on the same edge as a read
    logic              fwd_valid_reg, fwd_valid_next;
    logic [SEM_W-1:0]  fwd_sem_reg;
    logic [SW-1:0]     fwd_data_reg;

    // output stage; woken_proc comes straight from the waiter read register
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, status_next;
    logic              out_woken_reg, woken_next;

    // memory ports
    logic [SW-1:0]     st_rd_data;
    logic [SW-1:0]     st_wr_data;
    logic              st_wr_en;
    logic [PROC_W-1:0] wt_rd_data;
    logic              wt_wr_en;
    logic [QW-1:0]     wt_rd_pos;
    logic [QW-1:0]     wt_wr_pos;

    // current state of the addressed semaphore
    logic [SW-1:0]     cur_state;
    logic              cur_locked;
    logic [QW-1:0]     cur_head;
    logic [CW-1:0]     cur_count;
    logic [SUMW-1:0]   tail_sum;
    logic [QW-1:0]     tail_pos;
    logic [QW-1:0]     head_inc;
    logic              q_full;
    logic              new_locked;
    logic [QW-1:0]     new_head;
    logic [CW-1:0]     new_count;
    logic              enqueue;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    sfwu_state_ram #(
        .NUM_SEMS (NUM_SEMS),
        .WIDTH    (SW)
    ) u_state_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (sem_map[s_tdata[SEM_ID_W-1:0]]),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (s1_sem_reg),
        .wr_data (st_wr_data)
    );

    sfwu_waiter_ram #(
        .DEPTH  (WT_DEP),
        .ADDR_W (WT_AW)
    ) u_waiter_ram (
        .aclk    (aclk),
        .rd_en   (advance),
        .rd_addr ({s1_sem_reg, wt_rd_pos}),
        .rd_data (wt_rd_data),
        .wr_en   (wt_wr_en),
        .wr_addr ({s1_sem_reg, wt_wr_pos}),
        .wr_data (s1_proc_reg)
    );

    // pick up the write that the memory read missed
    assign cur_state = (fwd_valid_reg && (fwd_sem_reg == s1_sem_reg)) ? fwd_data_reg
                                                                       : st_rd_data;
    assign cur_locked = cur_state[SW-1];
    assign cur_head   = cur_state[CW +: QW];
    assign cur_count  = cur_state[CW-1:0];

    // ring arithmetic on slot positions; the sum stays below twice the depth
    assign tail_sum = SUMW'(cur_head) + SUMW'(cur_count);
    assign tail_pos = (tail_sum >= SUMW'(QUEUE_DEPTH)) ? QW'(tail_sum - SUMW'(QUEUE_DEPTH))
                                                       : QW'(tail_sum);
    assign head_inc = (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
    assign q_full   = (cur_count == CW'(QUEUE_DEPTH));

    always_comb begin
        new_locked  = cur_locked;
        new_head    = cur_head;
        new_count   = cur_count;
        enqueue     = 1'b0;
        woken_next  = 1'b0;
        status_next = ST_GRANTED;
        unique case (s1_op_reg)
            OP_WAIT: begin
                if (!cur_locked) begin
                    new_locked  = 1'b1;
                    status_next = ST_GRANTED;
                end else if (q_full) begin
                    status_next = ST_FULL;
                end else begin
                    enqueue     = 1'b1;
                    new_count   = cur_count + 1'b1;
                    status_next = ST_BLOCKED;
                end
            end
            OP_SIGNAL: begin
                if (cur_count == '0) begin
                    new_locked  = 1'b0;
                    status_next = ST_FREED;
                end else begin
                    // ownership passes to the oldest waiter
                    new_locked  = 1'b1;
                    new_head    = head_inc;
                    new_count   = cur_count - 1'b1;
                    woken_next  = 1'b1;
                    status_next = ST_HANDED;
                end
            end
            default: begin
                status_next = ST_GRANTED;
            end
        endcase
    end

    assign st_wr_data = {new_locked, new_head, new_count};
    assign st_wr_en   = s1_valid_reg && advance;
    assign wt_wr_en   = st_wr_en && enqueue;
    assign wt_wr_pos  = tail_pos;
    assign wt_rd_pos  = cur_head;

    // control next values; all hold while the output is stalled
    always_comb begin
        s1_valid_next  = s1_valid_reg;
        fwd_valid_next = fwd_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            s1_valid_next  = accept;
            fwd_valid_next = s1_valid_reg;
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg   <= op_t'(s_tuser);
            s1_sem_reg  <= sem_map[s_tdata[SEM_ID_W-1:0]];
            s1_proc_reg <= s_tdata[SEM_ID_W +: PROC_W];
        end
        if (advance) begin
            fwd_sem_reg    <= s1_sem_reg;
            fwd_data_reg   <= st_wr_data;
            out_status_reg <= status_next;
            out_woken_reg  <= woken_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_woken_reg ? wt_rd_data : '0;
    assign m_tuser  = {out_woken_reg, out_status_reg};

endmodule

// File: rtl/core/sfwu_checker.sv
// port-level checks of the semaphore fifo wait unit, bound to the top level
// depends on sfwu_pkg and semaphore_fifo_wait_unit_top_assert.svh
`include "semaphore_fifo_wait_unit_top_assert.svh"

module sfwu_checker
    import sfwu_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [PROC_W-1:0]    m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // a stalled result holds
`SFWU_ASSERT_NEXT(a_hold, (m_tvalid && !m_tready), (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

    // no result survives a reset
`SFWU_ASSERT_NEXT_ALWAYS(a_reset, (!aresetn), (!m_tvalid))

    // a woken waiter comes only with a hand-over
`SFWU_ASSERT_IMP(a_woken_status, m_tvalid, (m_tuser[3] == (m_tuser[2:0] == ST_HANDED)))

    // no waiter id without a wake
`SFWU_ASSERT_IMP(a_woken_zero, (m_tvalid && !m_tuser[3]), (m_tdata == '0))

endmodule

bind semaphore_fifo_wait_unit_top sfwu_checker u_sfwu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: verif/sfwu_outcome_checker.sv
`timescale 1ns / 100ps
// checker for the semaphore fifo wait unit: watches both channels, predicts each
// request's outcome and compares it with what the block returns; depends on sfwu_pkg
module sfwu_outcome_checker
    import sfwu_pkg::*;
#(
    parameter int NUM_SEMS    = DEF_NUM_SEMS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [3:0] sem_id, [11:4] proc_id, [15:12] zero
    input  logic                 s_tuser,   // [0] op
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [PROC_W-1:0]    m_tdata,   // [7:0] woken_proc
    input  logic [M_TUSER_W-1:0] m_tuser,   // [2:0] status, [3] woken_valid
    output int unsigned          mismatch_count,
    output int unsigned          pending_count
);

    localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH) + 1;
    localparam int SHOWN   = 60;  // stop printing details past this many failures

    typedef struct packed {
        status_t           status;
        logic              woken_valid;
        logic [PROC_W-1:0] woken_proc;
    } outcome_t;

    // shadow of the semaphore bank
    logic                locked    [NUM_SEMS];
    logic [PROC_W-1:0]   waiters   [NUM_SEMS*QUEUE_DEPTH];
    logic [HEAD_W-1:0]   q_head    [NUM_SEMS];
    logic [COUNT_W-1:0]  q_count   [NUM_SEMS];

    outcome_t awaited_outcomes[$];

    function automatic outcome_t resolve_request(input op_t op,
                                                 input logic [SEM_ID_W-1:0] sem_raw,
                                                 input logic [PROC_W-1:0] proc);
        int unsigned sem;
        int unsigned slot;
        outcome_t    res;
        sem             = sem_raw % NUM_SEMS;
        res.woken_valid = 1'b0;
        res.woken_proc  = '0;
        if (op == OP_WAIT) begin
            if (!locked[sem]) begin
                locked[sem] = 1'b1;
                res.status  = ST_GRANTED;
            end else if (q_count[sem] >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // append at the tail, behind everyone already waiting
                slot = sem * QUEUE_DEPTH + (int'(q_head[sem]) + int'(q_count[sem])) % QUEUE_DEPTH;
                waiters[slot] = proc;
                q_count[sem]  = q_count[sem] + 1'b1;
                res.status    = ST_BLOCKED;
            end
        end else begin
            if (q_count[sem] == 0) begin
                locked[sem] = 1'b0;
                res.status  = ST_FREED;
            end else begin
                // ownership passes to the oldest waiter, lock stays set
                slot            = sem * QUEUE_DEPTH + q_head[sem];
                res.woken_valid = 1'b1;
                res.woken_proc  = waiters[slot];
                q_head[sem]     = HEAD_W'((int'(q_head[sem]) + 1) % QUEUE_DEPTH);
                q_count[sem]    = q_count[sem] - 1'b1;
                res.status      = ST_HANDED;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        logic     bad;
        if (!aresetn) begin
            for (int i = 0; i < NUM_SEMS; i++) begin
                locked[i]  = 1'b0;
                q_head[i]  = '0;
                q_count[i] = '0;
            end
            awaited_outcomes.delete();
        end else begin
            // results first: a request taken at this edge cannot answer at the same edge
            if (m_tvalid && m_tready) begin
                if (awaited_outcomes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN)
                        $display("%0t: unexpected result, status %0d woken %b proc %0h",
                                 $time, m_tuser[STATUS_W-1:0], m_tuser[STATUS_W], m_tdata);
                end else begin
                    want = awaited_outcomes.pop_front();
                    bad  = 1'b0;
                    if (m_tuser[STATUS_W-1:0] !== want.status) begin
                        bad = 1'b1;
                        if (mismatch_count < SHOWN)
                            $display("%0t: status expected %0d, got %0d",
                                     $time, want.status, m_tuser[STATUS_W-1:0]);
                    end
                    if (m_tuser[STATUS_W] !== want.woken_valid) begin
                        bad = 1'b1;
                        if (mismatch_count < SHOWN)
                            $display("%0t: woken_valid expected %b, got %b",
                                     $time, want.woken_valid, m_tuser[STATUS_W]);
                    end
                    if (m_tdata !== want.woken_proc) begin
                        bad = 1'b1;
                        if (mismatch_count < SHOWN)
                            $display("%0t: woken_proc expected %0h, got %0h",
                                     $time, want.woken_proc, m_tdata);
                    end
                    if (bad)
                        mismatch_count++;
                end
            end
            if (s_tvalid && s_tready)
                awaited_outcomes.push_back(resolve_request(op_t'(s_tuser),
                                                           s_tdata[SEM_ID_W-1:0],
                                                           s_tdata[SEM_ID_W +: PROC_W]));
        end
        pending_count = awaited_outcomes.size();
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// top of the semaphore fifo wait unit regression: clock, reset, request stimulus,
// result-side stalls and the verdict; depends on sfwu_pkg, sfwu_outcome_checker and the top level
module tb;
    import sfwu_pkg::*;

    localparam int NUM_SEMS    = DEF_NUM_SEMS;
    localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
    localparam int PHASES      = 19;
    localparam int PHASE_LEN   = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;      // margin after the last outstanding result

    // receiver behaviors, each chosen at random when the mode timer runs out
    typedef enum logic [1:0] {
        RX_STREAM,   // always ready
        RX_COIN,     // ready half the time
        RX_SPARSE,   // ready one cycle in four
        RX_CADENCE   // fixed rhythm of stalls, set by the mode timer
    } rx_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [3:0] sem_id, [11:4] proc_id, [15:12] zero
    logic                 s_tuser  = 1'b0; // [0] op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [PROC_W-1:0]    m_tdata;         // [7:0] woken_proc
    logic [M_TUSER_W-1:0] m_tuser;         // [2:0] status, [3] woken_valid

    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned cycle_count = 0;

    rx_mode_t    rx_mode  = RX_STREAM;
    int unsigned rx_timer = 0;

    always #10 aclk = ~aclk;

    semaphore_fifo_wait_unit_top #(
        .NUM_SEMS    (NUM_SEMS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sfwu_outcome_checker #(
        .NUM_SEMS    (NUM_SEMS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) outcome_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // called at a falling edge; holds the request until it is taken, returns at the
    // following falling edge with s_tvalid still high so a burst can continue
    task automatic send_request(input op_t op, input logic [SEM_ID_W-1:0] sem,
                                input logic [PROC_W-1:0] proc);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {{(S_TDATA_W-SEM_ID_W-PROC_W){1'b0}}, proc, sem};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // sender gap: valid low for the given number of cycles
    task automatic hold_off(input int unsigned cycles);
        s_tvalid = 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // result side stalls on its own schedule, changing at the falling edge
    always @(negedge aclk) begin
        if (rx_timer == 0) begin
            rx_mode  = rx_mode_t'($urandom_range(0, 3));
            rx_timer = $urandom_range(16, 96);
        end else begin
            rx_timer = rx_timer - 1;
        end
        case (rx_mode)
            RX_STREAM:  m_tready = 1'b1;
            RX_COIN:    m_tready = 1'($urandom_range(0, 1));
            RX_SPARSE:  m_tready = ($urandom_range(0, 3) == 0);
            default:    m_tready = (rx_timer % 5) != 0;
        endcase
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("semaphore_fifo_wait_unit_top regression: fail");
            $finish;
        end
    end

    initial begin
        int unsigned wait_pct;
        int unsigned hot_sem;
        int unsigned burst_left;
        bit          scatter;
        bit          gapless;
        op_t         op;
        logic [SEM_ID_W-1:0] sem;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: grant, queue, hand over, release, release while free
        send_request(OP_WAIT,   4'd0, 8'h00);   // free semaphore, granted
        send_request(OP_WAIT,   4'd0, 8'hFF);   // locked, queued
        send_request(OP_SIGNAL, 4'd0, 8'h11);   // handed to the 0xff waiter
        send_request(OP_SIGNAL, 4'd0, 8'hFF);   // nobody waits, released
        send_request(OP_SIGNAL, 4'd0, 8'h00);   // signal on a free semaphore

        // top semaphore: holder waits on itself, then fill the queue until full
        send_request(OP_WAIT, 4'd15, 8'hAA);
        send_request(OP_WAIT, 4'd15, 8'hAA);    // self wait is queued
        for (int i = 1; i < QUEUE_DEPTH; i++)
            send_request(OP_WAIT, 4'd15, 8'(i * 17 + 3));
        send_request(OP_WAIT,   4'd15, 8'h55);  // queue full, not queued
        send_request(OP_SIGNAL, 4'd15, 8'h00);  // oldest waiter (the self wait) handed over
        send_request(OP_WAIT,   4'd15, 8'h5A);  // slot freed, queued at wrapped tail

        // random phases: each picks a wait/signal mix and either a hot pair of
        // semaphores (deep queues, full and hand-over) or the whole bank
        burst_left = 0;
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 3))
                0:       wait_pct = 20;
                1:       wait_pct = 50;
                2:       wait_pct = 75;
                default: wait_pct = 95;
            endcase
            hot_sem = $urandom_range(0, NUM_SEMS - 1);
            scatter = ($urandom_range(0, 3) == 0);
            gapless = ($urandom_range(0, 4) == 0);
            for (int n = 0; n < PHASE_LEN; n++) begin
                sem = scatter ? SEM_ID_W'($urandom_range(0, NUM_SEMS - 1))
                              : SEM_ID_W'(hot_sem ^ $urandom_range(0, 1));
                op  = ($urandom_range(0, 99) < wait_pct) ? OP_WAIT : OP_SIGNAL;
                send_request(op, sem, PROC_W'($urandom_range(0, 255)));
                if (!gapless) begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        hold_off($urandom_range(0, 6));
                    end else begin
                        burst_left--;
                    end
                end
            end
        end

        // drain: wait for every outstanding result, then a little longer
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("semaphore_fifo_wait_unit_top regression: pass");
        else
            $display("semaphore_fifo_wait_unit_top regression: fail");
        $finish;
    end

endmodule
